// ----- hw/rtl/lbp3_pkg.sv -----
// Package for the 3x3 local binary pattern unit.
// Shared widths, register indexes, neighbor order and stage types.
// No dependencies.
`timescale 1ns / 1ps
package lbp3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_LINES    = 4096;
   localparam int PIXEL_BITS   = 16;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = $clog2(MAX_LINES);
   localparam int WIDTH_BITS   = COL_BITS + 1;
   localparam int LINES_BITS   = ROW_BITS + 1;
   localparam int CODE_BITS    = 8;
   localparam int CSR_IDX_BITS = 8;
   localparam int CSR_DAT_BITS = 13;

   localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = WIDTH_BITS'(3);
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);
   localparam logic [LINES_BITS-1:0] LINES_MIN   = LINES_BITS'(3);
   localparam logic [LINES_BITS-1:0] LINES_MAX   = LINES_BITS'(MAX_LINES);
   localparam logic [LINES_BITS-1:0] LINES_RESET = LINES_BITS'(480);

   localparam logic [CSR_IDX_BITS-1:0] CSR_LINE_WIDTH = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_LINE_COUNT = CSR_IDX_BITS'(1);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [CODE_BITS-1:0]  code_type;

   // window slot for code bits 0..7:
   // left, below-left, below, below-right, right, above-right, above, above-left
   localparam logic [3:0] NEIGHBOR_IDX [CODE_BITS] =
      '{4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0};
   localparam logic [3:0] CENTER_IDX = 4'd4;

   typedef struct packed {
      logic    op;
      logic    emit;
      logic    interior;
      logic    frame_end;
      row_type row;
      col_type col;
      col_type addr;
   } stage_type;

endpackage

// ----- hw/rtl/lbp3_if.sv -----
// Valid/ready channel interfaces for the LBP unit: pixel in, code out, CSR writes.
// Depends on lbp3_pkg.
`timescale 1ns / 1ps
interface lbp3_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   lbp3_pkg::pixel_type  pixel;

   modport source (output valid, output op, output pixel, input ready);
   modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface lbp3_rsp_if;
   logic                valid;
   logic                ready;
   lbp3_pkg::code_type  code;
   lbp3_pkg::row_type   row;
   lbp3_pkg::col_type   col;
   logic                frame_end;

   modport source (output valid, output code, output row, output col, output frame_end,
                   input ready);
   modport sink   (input valid, input code, input row, input col, input frame_end,
                   output ready);
endinterface

interface lbp3_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [lbp3_pkg::CSR_IDX_BITS-1:0]     index;
   logic [lbp3_pkg::CSR_DAT_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lbp3_line_store.sv -----
// Two line stores (upper and middle) with registered read data.
// A write moves the middle entry read earlier into upper and the new pixel into middle.
// Depends on lbp3_pkg.
`timescale 1ns / 1ps
module lbp3_line_store (
   input  logic                 clock,
   input  logic                 rd_en,
   input  lbp3_pkg::col_type    rd_addr,
   input  logic                 wr_en,
   input  lbp3_pkg::col_type    wr_addr,
   input  lbp3_pkg::pixel_type  wr_pixel,
   output lbp3_pkg::pixel_type  upper_q,
   output lbp3_pkg::pixel_type  middle_q
);

   lbp3_pkg::pixel_type upper_mem  [lbp3_pkg::MAX_WIDTH];
   lbp3_pkg::pixel_type middle_mem [lbp3_pkg::MAX_WIDTH];
   lbp3_pkg::pixel_type upper_ff;
   lbp3_pkg::pixel_type middle_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_ff  <= upper_mem[rd_addr];
         middle_ff <= middle_mem[rd_addr];
      end
      if (wr_en) begin
         upper_mem[wr_addr]  <= middle_ff;
         middle_mem[wr_addr] <= wr_pixel;
      end
   end

   assign upper_q  = upper_ff;
   assign middle_q = middle_ff;

endmodule

// ----- hw/rtl/lbp3_window.sv -----
// 3x3 pixel window and LBP code of the window after the next shift.
// Depends on lbp3_pkg.
`timescale 1ns / 1ps
module lbp3_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  lbp3_pkg::pixel_type  upper,
   input  lbp3_pkg::pixel_type  middle,
   input  lbp3_pkg::pixel_type  pixel,
   output lbp3_pkg::code_type   code
);

   lbp3_pkg::pixel_type window_ff [9];
   lbp3_pkg::pixel_type window_in [9];

   always_comb begin
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = upper;
      window_in[3] = window_ff[4];
      window_in[4] = window_ff[5];
      window_in[5] = middle;
      window_in[6] = window_ff[7];
      window_in[7] = window_ff[8];
      window_in[8] = pixel;
   end

   always_comb begin
      for (int k = 0; k < lbp3_pkg::CODE_BITS; k++) begin
         code[k] = window_in[lbp3_pkg::CENTER_IDX] > window_in[lbp3_pkg::NEIGHBOR_IDX[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (shift_en) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- hw/rtl/local_binary_pattern_3x3_unit.sv -----
// Streaming 3x3 local binary pattern unit, top level.
// Depends on lbp3_pkg, lbp3_if, lbp3_line_store and lbp3_window.
`timescale 1ns / 1ps
// Accepts one transaction per clock: a pixel in raster order (op 0) or a flush
// tick (op 1). A pixel's code leaves with the transaction that brings the pixel
// line_width + 1 places later. That code passes the stage 1 register (beside the
// line store read register) and then the result register; a stalled output holds
// it in stage 1. Flush ticks drain the last pending codes of a frame as border
// codes. Throughput is one transaction per cycle: each line store has one read
// port and one write port, used once per cycle. A code held at a stalled output
// blocks the input. The line stores are not cleared; unwritten entries only feed
// border codes. A line width or line count write restarts the frame position and
// drops pending codes; write only while the unit is idle.
module local_binary_pattern_3x3_unit (
   input  logic              clock,
   input  logic              reset,
   lbp3_req_if.sink          req_chan,
   lbp3_rsp_if.source        rsp_chan,
   lbp3_csr_if.sink          csr_chan
);

   localparam int WB = lbp3_pkg::WIDTH_BITS;
   localparam int LB = lbp3_pkg::LINES_BITS;

   logic [WB-1:0] eff_w_ff, eff_w_in;
   logic [LB-1:0] eff_h_ff, eff_h_in;
   logic [WB-1:0] pend_ff, pend_in;
   lbp3_pkg::row_type in_row_ff, in_row_in, out_row_ff, out_row_in;
   lbp3_pkg::col_type in_col_ff, in_col_in, out_col_ff, out_col_in;

   logic                s1_valid_ff, s1_valid_in;
   lbp3_pkg::stage_type s1_ff, s1_in;
   lbp3_pkg::pixel_type s1_pixel_ff;

   logic                out_valid_ff, out_valid_in;
   lbp3_pkg::code_type  out_code_ff;
   lbp3_pkg::row_type   out_rrow_ff;
   lbp3_pkg::col_type   out_rcol_ff;
   logic                out_fend_ff;

   logic accept, csr_write, is_pixel, emit, stall, s1_done, s1_emit_now, s1_shift;
   logic [WB-1:0] width_wr;
   logic [LB-1:0] lines_wr;
   logic [WB-1:0] in_col_next, out_col_next;
   logic [LB-1:0] in_row_next, out_row_next;
   lbp3_pkg::pixel_type upper_q, middle_q;
   lbp3_pkg::code_type  win_code;

   assign stall       = s1_valid_ff && s1_ff.emit && out_valid_ff && !rsp_chan.ready;
   assign req_chan.ready = !stall;
   assign accept      = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_write   = csr_chan.valid && csr_chan.ready;
   assign is_pixel    = (req_chan.op == lbp3_pkg::OP_PIXEL);
   assign emit        = is_pixel ? (pend_ff == WB'(eff_w_ff + WB'(1))) : (pend_ff != '0);
   assign s1_done     = s1_valid_ff && !stall;
   assign s1_emit_now = s1_done && s1_ff.emit;
   assign s1_shift    = s1_done && (s1_ff.op == lbp3_pkg::OP_PIXEL);

   // register write clamping
   always_comb begin
      width_wr = csr_chan.data[WB-1:0];
      if (width_wr < lbp3_pkg::WIDTH_MIN) width_wr = lbp3_pkg::WIDTH_MIN;
      if (width_wr > lbp3_pkg::WIDTH_MAX) width_wr = lbp3_pkg::WIDTH_MAX;
      lines_wr = csr_chan.data[LB-1:0];
      if (lines_wr < lbp3_pkg::LINES_MIN) lines_wr = lbp3_pkg::LINES_MIN;
      if (lines_wr > lbp3_pkg::LINES_MAX) lines_wr = lbp3_pkg::LINES_MAX;
   end

   assign in_col_next  = WB'({1'b0, in_col_ff} + WB'(1));
   assign in_row_next  = LB'({1'b0, in_row_ff} + LB'(1));
   assign out_col_next = WB'({1'b0, out_col_ff} + WB'(1));
   assign out_row_next = LB'({1'b0, out_row_ff} + LB'(1));

   always_comb begin
      eff_w_in   = eff_w_ff;
      eff_h_in   = eff_h_ff;
      pend_in    = pend_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (csr_write) begin
         unique case (csr_chan.index)
            lbp3_pkg::CSR_LINE_WIDTH: eff_w_in = width_wr;
            lbp3_pkg::CSR_LINE_COUNT: eff_h_in = lines_wr;
            default: ;
         endcase
         if (csr_chan.index == lbp3_pkg::CSR_LINE_WIDTH ||
             csr_chan.index == lbp3_pkg::CSR_LINE_COUNT) begin
            pend_in    = '0;
            in_row_in  = '0;
            in_col_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
         end
      end else if (accept) begin
         if (is_pixel) begin
            if (in_col_next >= eff_w_ff) begin
               in_col_in = '0;
               in_row_in = (in_row_next >= eff_h_ff) ? '0 : in_row_next[lbp3_pkg::ROW_BITS-1:0];
            end else begin
               in_col_in = in_col_next[lbp3_pkg::COL_BITS-1:0];
            end
         end
         if (emit) begin
            if (out_col_next >= eff_w_ff) begin
               out_col_in = '0;
               out_row_in = (out_row_next >= eff_h_ff) ? '0
                            : out_row_next[lbp3_pkg::ROW_BITS-1:0];
            end else begin
               out_col_in = out_col_next[lbp3_pkg::COL_BITS-1:0];
            end
         end
         if (is_pixel && !emit) pend_in = WB'(pend_ff + WB'(1));
         else if (!is_pixel && emit) pend_in = WB'(pend_ff - WB'(1));
      end
   end

   always_comb begin
      s1_in.op        = req_chan.op;
      s1_in.emit      = emit;
      s1_in.row       = out_row_ff;
      s1_in.col       = out_col_ff;
      s1_in.addr      = in_col_ff;
      s1_in.interior  = is_pixel && (out_row_ff != '0) && (out_col_ff != '0) &&
                        ({1'b0, out_row_ff} <= LB'(eff_h_ff - LB'(2))) &&
                        ({1'b0, out_col_ff} <= WB'(eff_w_ff - WB'(2)));
      s1_in.frame_end = ({1'b0, out_row_ff} == LB'(eff_h_ff - LB'(1))) &&
                        ({1'b0, out_col_ff} == WB'(eff_w_ff - WB'(1)));
      s1_valid_in = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_emit_now ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   lbp3_line_store u_line_store (
      .clock    (clock),
      .rd_en    (accept && is_pixel),
      .rd_addr  (in_col_ff),
      .wr_en    (s1_shift),
      .wr_addr  (s1_ff.addr),
      .wr_pixel (s1_pixel_ff),
      .upper_q  (upper_q),
      .middle_q (middle_q)
   );

   lbp3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_shift),
      .upper    (upper_q),
      .middle   (middle_q),
      .pixel    (s1_pixel_ff),
      .code     (win_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff     <= lbp3_pkg::WIDTH_RESET;
         eff_h_ff     <= lbp3_pkg::LINES_RESET;
         pend_ff      <= '0;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         eff_w_ff     <= eff_w_in;
         eff_h_ff     <= eff_h_in;
         pend_ff      <= pend_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         s1_pixel_ff <= req_chan.pixel;
      end
      if (s1_emit_now) begin
         out_code_ff <= s1_ff.interior ? win_code : '0;
         out_rrow_ff <= s1_ff.row;
         out_rcol_ff <= s1_ff.col;
         out_fend_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.code      = out_code_ff;
   assign rsp_chan.row       = out_rrow_ff;
   assign rsp_chan.col       = out_rcol_ff;
   assign rsp_chan.frame_end = out_fend_ff;

endmodule

// ----- sim/tb.sv -----
// Testbench for local_binary_pattern_3x3_unit: random pixel streams and flushes under
// bursty input, random output stalls and CSR reconfiguration, checked against a predictor.
// Depends on lbp3_pkg, lbp3_if and the unit's RTL.
`timescale 1ns / 1ps
module tb;

   localparam int IDX_BITS = lbp3_pkg::CSR_IDX_BITS;
   localparam int DAT_BITS = lbp3_pkg::CSR_DAT_BITS;
   localparam int WID_BITS = lbp3_pkg::WIDTH_BITS;
   localparam int LIN_BITS = lbp3_pkg::LINES_BITS;

   typedef struct packed {
      logic                op;
      lbp3_pkg::pixel_type pixel;
   } stream_item_type;

   typedef struct packed {
      lbp3_pkg::code_type code;
      lbp3_pkg::row_type  row;
      lbp3_pkg::col_type  col;
      logic               frame_end;
   } lbp_result_type;

   localparam int RAND_ITEMS    = 760;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int AT_IN         = 0;
   localparam int AT_OUT        = 1;
   localparam logic [IDX_BITS-1:0] CSR_FIRST_UNUSED = IDX_BITS'(2);

   logic clock;
   logic reset;

   lbp3_req_if req_chan ();
   lbp3_rsp_if rsp_chan ();
   lbp3_csr_if csr_chan ();

   local_binary_pattern_3x3_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // predictor state
   lbp3_pkg::pixel_type   upper_line [lbp3_pkg::MAX_WIDTH];
   lbp3_pkg::pixel_type   middle_line [lbp3_pkg::MAX_WIDTH];
   lbp3_pkg::pixel_type   win [9];
   int                    pos_row [2];
   int                    pos_col [2];
   logic [WID_BITS-1:0]   width_reg;
   logic [LIN_BITS-1:0]   lines_reg;

   stream_item_type pixel_stream [$];
   lbp_result_type  code_queue [$];
   lbp_result_type  want_code;

   logic req_fire;
   logic hold_armed;
   int   burst_left, gap_left;
   int   hold_left, stall_mode, stall_left;
   int   items_sent, results_seen, csr_writes, frames_done, fail_count, queued_items;

   function automatic int clamp_width(logic [WID_BITS-1:0] raw);
      if (raw < lbp3_pkg::WIDTH_MIN) return int'(lbp3_pkg::WIDTH_MIN);
      if (raw > lbp3_pkg::WIDTH_MAX) return int'(lbp3_pkg::WIDTH_MAX);
      return int'(raw);
   endfunction

   function automatic int clamp_lines(logic [LIN_BITS-1:0] raw);
      if (raw < lbp3_pkg::LINES_MIN) return int'(lbp3_pkg::LINES_MIN);
      if (raw > lbp3_pkg::LINES_MAX) return int'(lbp3_pkg::LINES_MAX);
      return int'(raw);
   endfunction

   task automatic advance_pos(int which, int w, int h);
      pos_col[which]++;
      if (pos_col[which] >= w) begin
         pos_col[which] = 0;
         pos_row[which]++;
         if (pos_row[which] >= h) pos_row[which] = 0;
      end
   endtask

   task automatic emit_code(lbp3_pkg::code_type code, int w, int h);
      lbp_result_type res;
      res.code      = code;
      res.row       = lbp3_pkg::row_type'(pos_row[AT_OUT]);
      res.col       = lbp3_pkg::col_type'(pos_col[AT_OUT]);
      res.frame_end = (pos_row[AT_OUT] == h - 1) && (pos_col[AT_OUT] == w - 1);
      code_queue.push_back(res);
      advance_pos(AT_OUT, w, h);
   endtask

   task automatic predict_lbp(stream_item_type item);
      int                  w, h, total, ahead, c, r, k;
      lbp3_pkg::pixel_type nb [8];
      lbp3_pkg::code_type  code;
      w     = clamp_width(width_reg);
      h     = clamp_lines(lines_reg);
      total = w * h;
      ahead = (pos_row[AT_IN] * w + pos_col[AT_IN] + total
               - (pos_row[AT_OUT] * w + pos_col[AT_OUT])) % total;
      if (item.op == lbp3_pkg::OP_FLUSH) begin
         if (ahead != 0) emit_code('0, w, h);
      end else begin
         c = pos_col[AT_IN];
         for (r = 0; r < 3; r++) begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
         end
         win[2] = upper_line[c];
         win[5] = middle_line[c];
         win[8] = item.pixel;
         upper_line[c]  = middle_line[c];
         middle_line[c] = item.pixel;
         advance_pos(AT_IN, w, h);
         if (ahead == w + 1) begin
            code = '0;
            if (pos_row[AT_OUT] >= 1 && pos_row[AT_OUT] <= h - 2 &&
                pos_col[AT_OUT] >= 1 && pos_col[AT_OUT] <= w - 2) begin
               // left, below-left, below, below-right, right, above-right, above, above-left
               nb = '{win[3], win[6], win[7], win[8], win[5], win[2], win[1], win[0]};
               for (k = 0; k < 8; k++) code[k] = win[4] > nb[k];
            end
            emit_code(code, w, h);
         end
      end
   endtask

   task automatic check_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
      if (expected_val !== actual_val) begin
         $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
         fail_count++;
      end
   endtask

   task automatic queue_item(logic op, lbp3_pkg::pixel_type pixel);
      stream_item_type item;
      item.op    = op;
      item.pixel = pixel;
      pixel_stream.push_back(item);
      queued_items++;
   endtask

   function automatic lbp3_pkg::pixel_type pick_pixel(int style);
      case (style)
         0:       return lbp3_pkg::pixel_type'($urandom_range(0, 3));
         1:       return $urandom_range(0, 1)
                         ? lbp3_pkg::pixel_type'(16'hFFFF - $urandom_range(0, 1))
                         : lbp3_pkg::pixel_type'($urandom_range(0, 1));
         2:       return lbp3_pkg::pixel_type'($urandom_range(16'h7FFE, 16'h8001));
         default: return lbp3_pkg::pixel_type'($urandom);
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_stream.size() != 0 || req_chan.valid || code_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [IDX_BITS-1:0] index, logic [DAT_BITS-1:0] data);
      logic known;
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock);
      while (!csr_chan.ready);
      known = 1'b1;
      case (index)
         lbp3_pkg::CSR_LINE_WIDTH: width_reg = data[WID_BITS-1:0];
         lbp3_pkg::CSR_LINE_COUNT: lines_reg = data[LIN_BITS-1:0];
         default:                  known = 1'b0;
      endcase
      if (known) begin
         pos_row = '{0, 0};
         pos_col = '{0, 0};
      end
      csr_writes++;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic configure_random();
      int sel;
      if ($urandom_range(0, 5) == 0)
         write_csr(IDX_BITS'($urandom_range(CSR_FIRST_UNUSED, 255)),
                   DAT_BITS'($urandom));
      sel = $urandom_range(0, 9);
      if (sel == 0)
         write_csr(lbp3_pkg::CSR_LINE_WIDTH, {2'($urandom), 11'($urandom_range(0, 2))});
      else if (sel != 1)
         write_csr(lbp3_pkg::CSR_LINE_WIDTH, {2'($urandom), 11'($urandom_range(3, 10))});
      sel = $urandom_range(0, 9);
      if (sel == 0)
         write_csr(lbp3_pkg::CSR_LINE_COUNT, DAT_BITS'($urandom_range(0, 2)));
      else if (sel == 1)
         write_csr(lbp3_pkg::CSR_LINE_COUNT,
                   DAT_BITS'($urandom_range(lbp3_pkg::MAX_LINES + 1, 8191)));
      else if (sel != 2)
         write_csr(lbp3_pkg::CSR_LINE_COUNT, DAT_BITS'($urandom_range(3, 8)));
   endtask

   task automatic queue_random_phase();
      int w, h, npix, style, i;
      logic noisy;
      w     = clamp_width(width_reg);
      h     = clamp_lines(lines_reg);
      style = $urandom_range(0, 4);
      noisy = ($urandom_range(0, 7) == 0);
      if (h > 16) npix = $urandom_range(1, 3 * w + 2);
      else if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, w * h);
      else npix = w * h * $urandom_range(1, 3);
      @(posedge clock);
      for (i = 0; i < npix; i++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            queue_item(lbp3_pkg::OP_FLUSH, lbp3_pkg::pixel_type'($urandom));
         queue_item(lbp3_pkg::OP_PIXEL, pick_pixel(style == 4 ? $urandom_range(0, 3) : style));
      end
      if ($urandom_range(0, 3) != 0)
         repeat (w + 1 + $urandom_range(0, 2))
            queue_item(lbp3_pkg::OP_FLUSH, lbp3_pkg::pixel_type'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("covered %0d transactions in, %0d codes out before timeout", items_sent,
               results_seen);
      $display("[local_binary_pattern_3x3_unit] ERROR");
      $finish;
   end

   // input driver
   always @(posedge clock) begin
      req_fire = req_chan.valid && req_chan.ready;
      if (req_fire) begin
         predict_lbp(pixel_stream.pop_front());
         items_sent++;
      end
   end

   always @(negedge clock) begin
      if (!reset && !(req_chan.valid && !req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pixel_stream.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.op    <= pixel_stream[0].op;
            req_chan.pixel <= pixel_stream[0].pixel;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver and checker
   always @(negedge clock) begin
      if (hold_armed) begin
         hold_left  = HOLD_CYCLES;
         hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
            2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.frame_end) frames_done++;
         if (code_queue.size() == 0) begin
            $error("unexpected code transaction: row %0d col %0d code %0h", rsp_chan.row,
                   rsp_chan.col, rsp_chan.code);
            fail_count++;
         end else begin
            want_code = code_queue.pop_front();
            check_field("code", want_code.code, rsp_chan.code);
            check_field("row", want_code.row, rsp_chan.row);
            check_field("col", want_code.col, rsp_chan.col);
            check_field("frame_end", want_code.frame_end, rsp_chan.frame_end);
         end
      end
   end

   initial begin
      int i, rand_start;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op    = lbp3_pkg::OP_PIXEL;
      req_chan.pixel = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = lbp3_pkg::CSR_LINE_WIDTH;
      csr_chan.data  = '0;
      req_fire       = 1'b0;
      hold_armed     = 1'b0;
      burst_left     = 0;
      gap_left       = 0;
      hold_left      = 0;
      stall_mode     = 0;
      stall_left     = 0;
      items_sent     = 0;
      results_seen   = 0;
      csr_writes     = 0;
      frames_done    = 0;
      fail_count     = 0;
      queued_items   = 0;
      width_reg      = lbp3_pkg::WIDTH_RESET;
      lines_reg      = lbp3_pkg::LINES_RESET;
      pos_row        = '{0, 0};
      pos_col        = '{0, 0};
      for (i = 0; i < lbp3_pkg::MAX_WIDTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest frame: peak centre, empty flush, partial frame flushed early
      write_csr(lbp3_pkg::CSR_LINE_WIDTH, DAT_BITS'(3));
      write_csr(lbp3_pkg::CSR_LINE_COUNT, DAT_BITS'(3));
      @(posedge clock);
      queue_item(lbp3_pkg::OP_FLUSH, '1);
      for (i = 0; i < 9; i++) queue_item(lbp3_pkg::OP_PIXEL, (i == 4) ? '1 : '0);
      repeat (4) queue_item(lbp3_pkg::OP_FLUSH, '0);
      for (i = 0; i < 5; i++)
         queue_item(lbp3_pkg::OP_PIXEL, (i == 4) ? '1 : lbp3_pkg::pixel_type'(i));
      repeat (5) queue_item(lbp3_pkg::OP_FLUSH, lbp3_pkg::pixel_type'($urandom));
      wait_idle();

      // output held off while input keeps coming
      rand_start = queued_items;
      write_csr(lbp3_pkg::CSR_LINE_WIDTH, DAT_BITS'(5));
      write_csr(lbp3_pkg::CSR_LINE_COUNT, DAT_BITS'(6));
      @(posedge clock);
      repeat (90) queue_item(lbp3_pkg::OP_PIXEL, pick_pixel($urandom_range(0, 3)));
      repeat (6) queue_item(lbp3_pkg::OP_FLUSH, '0);
      hold_armed = 1'b1;

      while (queued_items - rand_start < RAND_ITEMS) begin
         wait_idle();
         configure_random();
         queue_random_phase();
      end

      // widest line, tallest frame
      wait_idle();
      write_csr(lbp3_pkg::CSR_LINE_WIDTH, {2'($urandom), 11'(lbp3_pkg::MAX_WIDTH)});
      write_csr(lbp3_pkg::CSR_LINE_COUNT, DAT_BITS'(lbp3_pkg::MAX_LINES));
      @(posedge clock);
      repeat (lbp3_pkg::MAX_WIDTH + 8)
         queue_item(lbp3_pkg::OP_PIXEL, lbp3_pkg::pixel_type'($urandom));
      repeat (8) queue_item(lbp3_pkg::OP_FLUSH, lbp3_pkg::pixel_type'($urandom));

      wait_idle();
      repeat (20) @(negedge clock);
      $display("covered %0d transactions in, %0d codes out, %0d CSR writes, %0d full frames",
               items_sent, results_seen, csr_writes, frames_done);
      if (fail_count == 0) begin
         $display("[local_binary_pattern_3x3_unit] OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[local_binary_pattern_3x3_unit] ERROR");
      end
      $finish;
   end

endmodule
